// ----- src/stable_quadratic_root_solver_top_assert.svh -----
// Assertion macros for the checker file, sqrs_checker.sv.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef STABLE_QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define STABLE_QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

// same-cycle implication
`define SQRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SQRS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sqrs_pkg.sv -----
package sqrs_pkg;

	localparam int COEF_W  = 32;
	localparam int DISC_W  = 66;
	localparam int ROOT_W  = DISC_W / 2;
	localparam int QDIV_W  = 34;
	localparam int NUM_W   = 49;
	localparam int PADDR_W = 3;

	// register index taken from paddr[2]
	localparam logic ZT_IDX = 1'b0;
	localparam logic [31:0] ZT_RESET = 32'd1;

	localparam logic [31:0] Q16_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q16_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_quad;
		logic signed [COEF_W-1:0] coef_lin;
		logic signed [COEF_W-1:0] coef_const;
	} in_t;

	typedef struct packed {
		logic [1:0]               root_count;
		logic signed [COEF_W-1:0] root_first;
		logic signed [COEF_W-1:0] root_second;
		logic                     overflow;
		logic                     bad_leading;
	} out_t;

	// sideband carried through the square root pipeline
	typedef struct packed {
		logic                     valid;
		logic                     bad;
		logic                     negd;
		logic                     one;
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
	} sq_side_t;

	// sideband carried through the divider pipeline
	typedef struct packed {
		logic bad;
		logic negd;
		logic one;
		logic bneg;
	} dv_side_t;

endpackage

// ----- src/sqrs_sqrt.sv -----
module sqrs_sqrt #(
	parameter int D_W    = 66,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [D_W-1:0]    rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic [D_W/2-1:0]  root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int RW = D_W / 2;
	localparam int MW = RW + 2;
	localparam int TW = MW + 2;

	logic [D_W-1:0]    rad_s  [RW+1];
	logic [MW-1:0]     rem_s  [RW+1];
	logic [RW-1:0]     root_s [RW+1];
	logic [SIDE_W-1:0] side_s [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[0] <= '0;
		end else if (en) begin
			side_s[0] <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= rad;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	// one root bit per stage, two radicand bits consumed
	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [TW-1:0] cur;
		logic [TW-1:0] trial;
		logic          fit;

		assign cur   = {rem_s[k], rad_s[k][D_W-1 -: 2]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign fit   = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1] <= '0;
			end else if (en) begin
				side_s[k+1] <= side_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= fit ? MW'(cur - trial) : cur[MW-1:0];
				root_s[k+1] <= {root_s[k][RW-2:0], fit};
				rad_s[k+1]  <= {rad_s[k][D_W-3:0], 2'b00};
			end
		end
	end

	assign root     = root_s[RW];
	assign side_out = side_s[RW];

endmodule

// ----- src/sqrs_div.sv -----
module sqrs_div #(
	parameter int NUM_W  = 49,
	parameter int DEN_W  = 34,
	parameter int SIDE_W = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	input  logic [SIDE_W-1:0]       side_in,
	output logic [NUM_W-1:0]        quot_mag,
	output logic                    quot_neg,
	output logic [SIDE_W-1:0]       side_out
);
	logic [NUM_W-1:0]  nq_s   [NUM_W+1];
	logic [DEN_W-1:0]  rem_s  [NUM_W+1];
	logic [DEN_W-1:0]  den_s  [NUM_W+1];
	logic              neg_s  [NUM_W+1];
	logic [SIDE_W-1:0] side_s [NUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[0] <= '0;
		end else if (en) begin
			side_s[0] <= side_in;
		end
	end

	// split into magnitudes, truncate toward zero by sign afterwards
	always_ff @(posedge clk) begin
		if (en) begin
			nq_s[0]  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			den_s[0] <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
			neg_s[0] <= num[NUM_W-1] ^ den[DEN_W-1];
			rem_s[0] <= '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic           fit;

		assign trial = {rem_s[k], nq_s[k][NUM_W-1]};
		assign fit   = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k+1] <= '0;
			end else if (en) begin
				side_s[k+1] <= side_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= fit ? DEN_W'(trial - {1'b0, den_s[k]}) : trial[DEN_W-1:0];
				nq_s[k+1]  <= {nq_s[k][NUM_W-2:0], fit};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quot_mag = nq_s[NUM_W];
	assign quot_neg = neg_s[NUM_W];
	assign side_out = side_s[NUM_W];

endmodule

// ----- src/stable_quadratic_root_solver_top.sv -----
// Quadratic root solver for a*x^2 + b*x + c = 0 with signed Q16.16 coefficients,
// using the cancellation-free form of the quadratic formula. The discriminant
// b*b - 4ac is formed exactly (66 bits, Q34.32); its floor square root s gives
// q = -(b+s) for b >= 0 or -b+s for b < 0, and the roots are q/(2a) and 2c/q,
// ordered so that x1 is q/(2a) when b >= 0 and 2c/q otherwise. Quotients
// truncate toward zero and saturate to Q16.16 with overflow set. A discriminant
// at or below zero_threshold (APB register 0, reset 1) reports one root;
// a negative one reports none; a zero a sets bad_leading. The block takes one
// item per clock unless the pipeline holds, through these stages in order:
// three front stages (magnitudes, the two 32x32 products, the discriminant),
// 34 stages of the bit-pair square root, one stage that forms q, 50 stages of
// two parallel restoring dividers (one quotient bit per stage) and the output
// register. A two-entry output buffer keeps input transfers flowing while a
// result waits; the pipeline holds only when both entries are full.
module stable_quadratic_root_solver_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  sqrs_pkg::in_t                in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output sqrs_pkg::out_t               out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sqrs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import sqrs_pkg::*;

	// saturate a quotient magnitude to Q16.16, returns {ovf, value}
	function automatic logic [32:0] sat_q16(input logic [NUM_W-1:0] mag, input logic neg);
		logic        ovf;
		logic [31:0] val;
		if (neg) begin
			ovf = mag > NUM_W'(Q16_MIN);
			val = ovf ? Q16_MIN : 32'(-mag[31:0]);
		end else begin
			ovf = mag > NUM_W'(Q16_MAX);
			val = ovf ? Q16_MAX : mag[31:0];
		end
		return {ovf, val};
	endfunction

	logic [31:0] thr_q;
	logic        en;
	logic [1:0]  cnt_q;
	out_t        e0_q, e1_q;
	logic        push, pop;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ZT_IDX) ? thr_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ZT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ZT_IDX) begin
			thr_q <= pwdata;
		end
	end

	// advance the whole pipeline unless the output buffer is full and held
	assign pop      = out_valid && !out_stall;
	assign en       = (cnt_q != 2'd2) || pop;
	assign in_stall = !en;

	// stage 1: capture and take magnitudes
	logic                     v_s1, v_s2, v_s3;
	logic signed [COEF_W-1:0] a_s1, b_s1, c_s1;
	logic [COEF_W-1:0]        am_s1, bm_s1, cm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= in_item.coef_quad;
			b_s1  <= in_item.coef_lin;
			c_s1  <= in_item.coef_const;
			am_s1 <= in_item.coef_quad[31] ? 32'(-in_item.coef_quad) : in_item.coef_quad;
			bm_s1 <= in_item.coef_lin[31] ? 32'(-in_item.coef_lin) : in_item.coef_lin;
			cm_s1 <= in_item.coef_const[31] ? 32'(-in_item.coef_const) : in_item.coef_const;
		end
	end

	// stage 2: b*b and |a*c|
	logic signed [COEF_W-1:0] a_s2, b_s2, c_s2;
	logic [63:0]              b2_s2, p_s2;
	logic                     add_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			c_s2   <= c_s1;
			b2_s2  <= bm_s1 * bm_s1;
			p_s2   <= am_s1 * cm_s1;
			// 4ac <= 0: discriminant is b*b + 4|ac|
			add_s2 <= (a_s1[31] != c_s1[31]) || (c_s1 == '0);
		end
	end

	// stage 3: discriminant
	logic signed [COEF_W-1:0] a_s3, b_s3, c_s3;
	logic [DISC_W-1:0]        d_s3;
	logic                     negd_s3;
	logic [DISC_W-1:0]        d_sum;
	logic [DISC_W:0]          d_dif;

	assign d_sum = {2'b00, b2_s2} + {p_s2, 2'b00};
	assign d_dif = {3'b000, b2_s2} - {1'b0, p_s2, 2'b00};

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			c_s3    <= c_s2;
			d_s3    <= add_s2 ? d_sum : d_dif[DISC_W-1:0];
			negd_s3 <= !add_s2 && d_dif[DISC_W];
		end
	end

	// square root pipeline
	sq_side_t          sq_in, sq_out;
	logic [ROOT_W-1:0] s_root;

	always_comb begin
		sq_in.valid = v_s3;
		sq_in.bad   = (a_s3 == '0);
		sq_in.negd  = negd_s3;
		sq_in.one   = (d_s3[DISC_W-1:32] == '0) && (d_s3[31:0] <= thr_q);
		sq_in.a     = a_s3;
		sq_in.b     = b_s3;
		sq_in.c     = c_s3;
	end

	sqrs_sqrt #(
		.D_W   (DISC_W),
		.SIDE_W($bits(sq_side_t))
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rad     (d_s3),
		.side_in (sq_in),
		.root    (s_root),
		.side_out(sq_out)
	);

	// stage 4: form q and the two divisions
	logic signed [ROOT_W+1:0] q_full;
	logic signed [ROOT_W+1:0] b_ext, s_ext;
	logic                     v_s4;
	dv_side_t                 dv_s4;
	logic signed [NUM_W-1:0]  numa_s4, numb_s4;
	logic signed [QDIV_W-1:0] dena_s4, denb_s4;

	assign b_ext  = (ROOT_W+2)'(sq_out.b);
	assign s_ext  = {2'b00, s_root};
	assign q_full = sq_out.b[31] ? (s_ext - b_ext) : -(b_ext + s_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s4.bad  <= sq_out.bad;
			dv_s4.negd <= sq_out.negd;
			dv_s4.one  <= sq_out.one;
			dv_s4.bneg <= sq_out.b[31];
			numa_s4    <= {q_full[QDIV_W-1:0], 15'b0};
			dena_s4    <= QDIV_W'(sq_out.a);
			numb_s4    <= {sq_out.c, 17'b0};
			denb_s4    <= q_full[QDIV_W-1:0];
		end
	end

	logic [NUM_W-1:0] maga, magb;
	logic             nega, negb;
	dv_side_t         dv_out;
	logic             v_div;

	// q / (2a) in Q16.16
	sqrs_div #(
		.NUM_W (NUM_W),
		.DEN_W (QDIV_W),
		.SIDE_W($bits(dv_side_t))
	) u_div_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.num     (numa_s4),
		.den     (dena_s4),
		.side_in (dv_s4),
		.quot_mag(maga),
		.quot_neg(nega),
		.side_out(dv_out)
	);

	// 2c / q in Q16.16; carries the valid bit
	sqrs_div #(
		.NUM_W (NUM_W),
		.DEN_W (QDIV_W),
		.SIDE_W(1)
	) u_div_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.num     (numb_s4),
		.den     (denb_s4),
		.side_in (v_s4),
		.quot_mag(magb),
		.quot_neg(negb),
		.side_out(v_div)
	);

	// assemble the result
	logic [32:0] sat_a, sat_b, sat1, sat2;
	out_t        res;

	assign sat_a = sat_q16(maga, nega);
	assign sat_b = sat_q16(magb, negb);
	assign sat1  = dv_out.bneg ? sat_b : sat_a;
	assign sat2  = dv_out.bneg ? sat_a : sat_b;

	always_comb begin
		res = '0;
		if (dv_out.bad) begin
			res.bad_leading = 1'b1;
		end else if (!dv_out.negd) begin
			res.root_count  = dv_out.one ? 2'd1 : 2'd2;
			res.root_first  = sat1[31:0];
			res.root_second = dv_out.one ? '0 : sat2[31:0];
			res.overflow    = sat1[32] || (!dv_out.one && sat2[32]);
		end
	end

	// two-entry output buffer, e0_q is the head
	assign push      = en && v_div;
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				e0_q <= e1_q;
				if (push) begin
					e1_q <= res;
				end
			end else if (push) begin
				e0_q <= res;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				e0_q <= res;
			end else begin
				e1_q <= res;
			end
		end
	end

endmodule

// ----- src/sqrs_checker.sv -----
`include "stable_quadratic_root_solver_top_assert.svh"

module sqrs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_stall,
	input sqrs_pkg::out_t out_item
);
	import sqrs_pkg::*;

	`SQRS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "held result changed")
	`SQRS_ASSERT_IMP(a_bad_clean, out_valid && out_item.bad_leading, out_item.root_count == 2'd0 && out_item.root_first == '0 && out_item.root_second == '0 && !out_item.overflow, "bad leading result not cleared")
	`SQRS_ASSERT_IMP(a_none_clean, out_valid && out_item.root_count == 2'd0, out_item.root_first == '0 && out_item.root_second == '0 && !out_item.overflow, "no-root result not cleared")
	`SQRS_ASSERT_IMP(a_single, out_valid && out_item.root_count != 2'd2, out_item.root_second == '0, "second root set without two roots")

endmodule

bind stable_quadratic_root_solver_top sqrs_checker u_sqrs_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	import sqrs_pkg::*;

	// Checking point: the design returns one result for each input transfer.
	// PIPE_DEPTH sets the drain allowance at the end and before register writes.
	localparam int PIPE_DEPTH = 89;
	localparam logic [PADDR_W-1:0] ZT_ADDR = '0;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	in_t            in_item;
	logic           out_valid;
	logic           out_stall;
	out_t           out_item;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	// Predicted root sets, oldest first.
	out_t           roots_pending[$];
	logic [31:0]    thr_shadow;
	int             mismatches;
	int             send_idle_pct;
	int             recv_stall_pct;
	bit             hold_request;
	int             hold_left;

	stable_quadratic_root_solver_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the whole run, far above the slowest correct run.
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	// Saturate a quotient to Q16.16 and flag the clip.
	function automatic logic [31:0] clip_q16(input longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return Q16_MAX;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return Q16_MIN;
		end
		return v[31:0];
	endfunction

	// Cancellation-free roots of a*x^2 + b*x + c at the given single-root threshold.
	function automatic out_t solve_quadratic(input in_t it, input logic [31:0] thr);
		out_t r;
		longint a, b, c, q, x1, x2, s;
		logic signed [71:0] disc;
		logic [71:0] trial;
		bit ovf, ovf2;
		r = '0;
		a = longint'(it.coef_quad);
		b = longint'(it.coef_lin);
		c = longint'(it.coef_const);
		ovf = 1'b0;
		ovf2 = 1'b0;
		if (a == 0) begin
			r.bad_leading = 1'b1;
			return r;
		end
		disc = 72'(b) * 72'(b) - 72'sd4 * 72'(a) * 72'(c);
		if (disc < 0)
			return r;
		r.root_count = (disc <= 72'(thr)) ? 2'd1 : 2'd2;
		// floor square root, one result bit at a time
		s = 0;
		for (int i = 32; i >= 0; i--) begin
			trial = 72'(s | (64'sd1 <<< i));
			if (trial * trial <= 72'(disc))
				s = s | (64'sd1 <<< i);
		end
		if (b >= 0) begin
			q = -(b + s);
			x1 = (q * 32768) / a;
			x2 = (q != 0) ? (c * 131072) / q : 0;
		end else begin
			q = -b + s;
			x1 = (c * 131072) / q;
			x2 = (q * 32768) / a;
		end
		r.root_first = clip_q16(x1, ovf);
		if (r.root_count == 2'd2)
			r.root_second = clip_q16(x2, ovf2);
		r.overflow = ovf | ovf2;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Compare every result transfer with the oldest prediction.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (roots_pending.size() == 0) begin
				report_mismatch("unexpected result", out_item.root_first, '0);
			end else begin
				want = roots_pending.pop_front();
				if (out_item.root_count !== want.root_count)
					report_mismatch("root_count", 32'(out_item.root_count),
						32'(want.root_count));
				if (out_item.root_first !== want.root_first)
					report_mismatch("root_first", out_item.root_first, want.root_first);
				if (out_item.root_second !== want.root_second)
					report_mismatch("root_second", out_item.root_second, want.root_second);
				if (out_item.overflow !== want.overflow)
					report_mismatch("overflow", 32'(out_item.overflow), 32'(want.overflow));
				if (out_item.bad_leading !== want.bad_leading)
					report_mismatch("bad_leading", 32'(out_item.bad_leading),
						32'(want.bad_leading));
			end
		end
	end

	// Receiver: random stall, plus a long hold when requested.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0)
			hold_left--;
		out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
	end

	// Offer one coefficient set; hold it until the transfer happens.
	task automatic send_coefs(input in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		roots_pending = {roots_pending, solve_quadratic(it, thr_shadow)};
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		wait (roots_pending.size() == 0);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [31:0] v);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ZT_ADDR;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		thr_shadow = v;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== v)
			report_mismatch("zero_threshold readback", prdata, v);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly solvable sets: perfect squares, near-double roots, small and full-range.
	function automatic in_t pick_coefs();
		in_t it;
		int u, v;
		case ($urandom_range(5))
			0: begin
				it.coef_quad  = $urandom;
				it.coef_lin   = $urandom;
				it.coef_const = $urandom;
			end
			1: begin
				u = $urandom_range(1, 255);
				v = $urandom_range(0, 255);
				it.coef_quad  = ($urandom_range(1)) ? u : -u;
				it.coef_lin   = 2 * it.coef_quad * v;
				it.coef_const = it.coef_quad * v * v
					+ int'($urandom_range(4)) - 2;
				if ($urandom_range(1))
					it.coef_lin = -it.coef_lin;
			end
			2: begin
				it.coef_quad  = int'($urandom_range(131072)) - 65536;
				it.coef_lin   = int'($urandom_range(1 << 24)) - (1 << 23);
				it.coef_const = int'($urandom_range(131072)) - 65536;
			end
			3: begin
				it.coef_quad  = int'($urandom_range(7)) - 3;
				it.coef_lin   = $urandom;
				it.coef_const = $urandom;
			end
			default: begin
				// opposite signs on a and c: always two real roots
				it.coef_quad  = $urandom;
				it.coef_const = $urandom;
				if (it.coef_quad[31] == it.coef_const[31])
					it.coef_const = -it.coef_const;
				it.coef_lin   = $urandom;
			end
		endcase
		return it;
	endfunction

	task automatic test_directed;
		in_t d[$];
		d = '{
			'{32'sd0, 32'sd65536, 32'sd65536},                    // zero leading
			'{32'sd0, -32'sd1, -32'sd1},
			'{32'sd65536, 32'sd0, 32'sd65536},                     // negative disc
			'{32'sd65536, 32'sd0, 32'sd0},                         // b = 0, D = 0
			'{32'sd65536, 32'sd131072, 32'sd65536},                // double root
			'{32'sd65536, -32'sd131072, 32'sd65536},
			'{32'sd65536, -32'sd196608, 32'sd131072},              // b < 0, two roots
			'{32'sd65536, 32'sd196608, 32'sd131072},               // b > 0
			'{32'sd1, 32'sd2147483647, 32'sd0},                    // overflow x1
			'{32'sd1, -32'sd2147483648, 32'sd1},
			'{32'sd2147483647, 32'sd2147483647, 32'sd2147483647},
			'{-32'sd2147483648, -32'sd2147483648, -32'sd2147483648},
			'{-32'sd2147483648, 32'sd2147483647, 32'sd2147483647},
			'{32'sd2147483647, -32'sd2147483648, -32'sd2147483648},
			'{-32'sd1, 32'sd0, 32'sd1},
			'{32'sd1, 32'sd2, 32'sd1},                             // D exactly 0
			'{32'sd1, 32'sd0, -32'sd0},
			'{32'sd1, 32'sd1, 32'sd0},                             // D = 1 at threshold
			'{32'sd1, 32'sd2, 32'sd0},                             // D = 4
			'{-32'sd1, -32'sd1, 32'sd0}
		};
		foreach (d[i])
			send_coefs(d[i]);
	endtask

	task automatic test_random(input int count, input int idle, input int stall);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		repeat (count)
			send_coefs(pick_coefs());
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// Hold the receiver while the sender keeps pushing: the block must stall its input.
	task automatic test_backpressure;
		hold_request = 1'b1;
		test_random(150, 0, 0);
	endtask

	task automatic test_thresholds;
		write_threshold(32'd0);
		test_directed();
		test_random(80, 20, 20);
		write_threshold(32'hFFFF_FFFF);
		test_directed();
		test_random(80, 20, 20);
		write_threshold($urandom);
		test_random(80, 20, 20);
		write_threshold($urandom_range(64));
		test_random(80, 0, 0);
		write_threshold(ZT_RESET);
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_item        = '0;
		out_stall      = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		thr_shadow     = ZT_RESET;
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		hold_left      = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(200, 0, 0);
		test_random(200, 45, 0);
		test_random(200, 0, 45);
		test_random(200, 29, 29);
		test_backpressure();
		test_thresholds();
		test_random(100, 29, 29);
		drain();

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
